>>> sv/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// shared types and fixed widths for the longest balanced run block
// ----------------------------------------------------------------------------
`default_nettype none

package lbr_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int LONGEST_W = 11;

    // one input transaction
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_item;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [LONGEST_W-1:0] longest;
        logic                 too_long;
    } result_t;

endpackage

`default_nettype wire

>>> sv/lbr_ram.sv
// ----------------------------------------------------------------------------
// lbr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/longest_balanced_run.sv
// ----------------------------------------------------------------------------
// longest_balanced_run
// streams a list of +1/-1 steps and reports the longest zero-sum run per list
// ----------------------------------------------------------------------------
//
//   channel   | dir | payload          | handshake
//   ----------+-----+------------------+-----------------------------
//   item      | in  | lbr_pkg::item_t   | item_valid / item_stall
//   result    | out | lbr_pkg::result_t | result_valid / result_stall
//
// one item transaction per cycle while item_stall is low, no bubbles between lists
// result_valid rises once a final item has passed both stages into the queue:
// stage 0 updates the prefix sum and issues one ram access, stage 1 uses
// the registered ram read, then the result sits in a two-entry output queue
// reset needs no clearing pass: the table carries no valid bits
// item_stall rises whenever the output queue will hold two results after this cycle
//
`default_nettype none

module longest_balanced_run #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire lbr_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output lbr_pkg::result_t      result
);

    import lbr_pkg::*;

    // position counts 0..MAX_LEN
    localparam int POS_W  = $clog2(MAX_LEN + 1);
    // table holds prefix values -MAX_LEN..MAX_LEN, prefix width equals address width
    localparam int DEPTH  = 2 * MAX_LEN + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BEST_X = (POS_W > LONGEST_W) ? POS_W : LONGEST_W;

    localparam logic signed [ADDR_W-1:0] PS_ONE    = ADDR_W'(1);
    localparam logic signed [ADDR_W-1:0] PS_ZERO   = ADDR_W'(0);
    localparam logic        [ADDR_W-1:0] SLOT_BIAS = ADDR_W'(MAX_LEN);
    localparam logic        [POS_W-1:0]  POS_MAX   = POS_W'(MAX_LEN);
    localparam logic        [POS_W-1:0]  POS_ONE   = POS_W'(1);

    // ------------------------------------------------------------------
    // stage 0: per-list running state
    // the prefix walk moves by one each step, so the set of prefix values
    // already visited in this list is exactly [min_reg, max_reg]; a value
    // is new only when it steps past either end, which stands in for the
    // per-list seen marks
    // ------------------------------------------------------------------
    logic signed [ADDR_W-1:0] prefix_reg, prefix_next;
    logic signed [ADDR_W-1:0] min_reg, min_next;
    logic signed [ADDR_W-1:0] max_reg, max_next;
    logic        [POS_W-1:0]  pos_reg, pos_next;
    logic                     ovf_reg, ovf_next;

    logic                     accept;
    logic                     counted;
    logic                     step_up;
    logic signed [ADDR_W-1:0] p_new;
    logic                     is_zero;
    logic                     is_new;
    logic        [POS_W-1:0]  pos_inc;
    logic        [ADDR_W-1:0] slot;
    logic                     wr_en;
    logic                     rd_en;

    // stage 1 registers
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic                     s1_ovf_reg;
    logic                     s1_zero_reg;
    logic                     s1_read_reg;
    logic        [POS_W-1:0]  s1_pos_reg;
    logic        [POS_W-1:0]  rd_data;
    logic        [POS_W-1:0]  best_reg, best_next;
    logic        [POS_W-1:0]  run_len;
    logic        [POS_W-1:0]  cand;
    logic        [POS_W-1:0]  best_upd;
    logic        [BEST_X-1:0] best_ext;

    // output queue
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;
    result_t                  out_reg, out_next;
    result_t                  skid_reg, skid_next;
    result_t                  push_data;
    logic                     push;
    logic                     pop;
    logic        [1:0]        occ_after;

    assign accept  = item_valid & ~item_stall;
    assign counted = (pos_reg != POS_MAX);
    assign step_up = (item.sample == SAMPLE_W'(1));
    assign p_new   = step_up ? (prefix_reg + PS_ONE) : (prefix_reg - PS_ONE);
    assign is_zero = (p_new == '0);
    assign is_new  = step_up ? (p_new > max_reg) : (p_new < min_reg);
    assign pos_inc = pos_reg + POS_ONE;
    // offset into the table, wraps cleanly in ADDR_W bits
    assign slot    = $unsigned(p_new) + SLOT_BIAS;

    // first visit records its position, a revisit reads the first one back
    assign wr_en = accept & counted & ~is_zero & is_new;
    assign rd_en = accept & counted & ~is_zero & ~is_new;

    always_comb
    begin
        prefix_next = prefix_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        pos_next    = pos_reg;
        ovf_next    = ovf_reg;
        if (accept)
        begin
            if (item.final_item)
            begin
                // list ends: start the next one clean
                prefix_next = '0;
                min_next    = '0;
                max_next    = '0;
                pos_next    = '0;
                ovf_next    = 1'b0;
            end
            else if (counted)
            begin
                prefix_next = p_new;
                pos_next    = pos_inc;
                if (p_new < min_reg)
                begin
                    min_next = p_new;
                end
                if (p_new > max_reg)
                begin
                    max_next = p_new;
                end
            end
            else
            begin
                // past MAX_LEN: dropped, only flagged
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            pos_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            pos_reg    <= pos_next;
            ovf_reg    <= ovf_next;
        end
    end

    // first position of each prefix value; entries are read only after
    // being written in the same list, and a write is never followed by a
    // read of that entry in the same cycle, so no forwarding is needed
    lbr_ram #(
        .WIDTH (POS_W),
        .DEPTH (DEPTH)
    ) u_first_seen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (pos_inc),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // stage 0 -> stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= item.final_item;
            s1_ovf_reg  <= ovf_reg | ~counted;
            s1_zero_reg <= counted & is_zero;
            s1_read_reg <= rd_en;
            s1_pos_reg  <= pos_inc;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: candidate run length and running best
    // a zero prefix is a run from the list start; a revisit spans back to
    // the recorded first position
    // ------------------------------------------------------------------
    assign run_len = s1_pos_reg - rd_data;

    always_comb
    begin
        cand = '0;
        if (s1_zero_reg)
        begin
            cand = s1_pos_reg;
        end
        else if (s1_read_reg)
        begin
            cand = run_len;
        end
    end

    assign best_upd = (cand > best_reg) ? cand : best_reg;

    always_comb
    begin
        best_next = best_reg;
        if (s1_valid_reg)
        begin
            best_next = s1_last_reg ? '0 : best_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    // longest is the best length masked to the result width
    assign best_ext           = BEST_X'(best_upd);
    assign push_data.longest  = best_ext[LONGEST_W-1:0];
    assign push_data.too_long = s1_ovf_reg;
    assign push               = s1_valid_reg & s1_last_reg;

    // ------------------------------------------------------------------
    // output queue: head register plus one skid entry
    // an item is taken only if the queue can still absorb the result of
    // the item in stage 1 and of the one being taken
    // ------------------------------------------------------------------
    assign pop       = out_valid_reg & ~result_stall;
    assign occ_after = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(push) - 2'(pop);
    assign item_stall = (occ_after >= 2'd2);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // queue fills head first
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while head is empty");

    // a full queue that is held must hold off new transactions
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_stall) |-> item_stall)
        else $error("input not stalled with full output queue");

    // visited range always covers the start value and the current prefix
    a_range_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (min_reg <= prefix_reg) && (prefix_reg <= max_reg) &&
        (min_reg <= PS_ZERO) && (max_reg >= PS_ZERO))
        else $error("prefix outside visited range");

    // at most one ram access per cycle
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("table read and write in the same cycle");

    // a final transaction clears the list state
    a_list_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.final_item) |=> (pos_reg == '0) && (prefix_reg == '0))
        else $error("list state not cleared after final transaction");

endmodule

`default_nettype wire

>>> dv/tb_longest_balanced_run.sv
// ----------------------------------------------------------------------------
// tb_longest_balanced_run
// streams lists of +1/-1 steps through the block and checks every reported
// longest balanced run against a prefix-sum tracker kept in the bench
// ----------------------------------------------------------------------------
module tb_longest_balanced_run;

    timeunit 1ns;
    timeprecision 1ps;

    import lbr_pkg::*;

    // list length cap of the block and the size of its first-position table
    localparam int RUN_CAP     = 1024;
    localparam int TABLE_DEPTH = 2 * RUN_CAP + 1;

    // cycles with no transaction on either channel before the run is abandoned
    localparam int STUCK_LIMIT = 4000;

    // how many mismatches are printed in full
    localparam int SHOWN_MISSES = 10;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // idle and stall rates in percent, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    int unsigned miss_count   = 0;
    int unsigned stuck_cycles = 0;

    // results the tracker has produced and the block has not yet delivered
    result_t pending_runs[$];

    // tracker state: running sum, list position, best run, overflow mark,
    // and the first position at which each prefix value was seen
    int          run_sum     = 0;
    int unsigned run_pos     = 0;
    int unsigned run_best    = 0;
    bit          run_dropped = 1'b0;
    int unsigned first_pos [0:TABLE_DEPTH-1];
    bit          seen      [0:TABLE_DEPTH-1];

    longest_balanced_run #(
        .MAX_LEN      (RUN_CAP)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // tracker: folds one accepted transaction into the running prefix sum and,
    // on the last element of a list, queues the run length that should come out
    // ------------------------------------------------------------------------
    function automatic void track_balance(item_t it);
        int      slot;
        result_t res;
        if (run_pos < RUN_CAP)
        begin
            run_pos++;
            // only the exact value one steps up, every other value steps down
            run_sum += (it.sample == 32'sd1) ? 1 : -1;
            if (run_sum == 0)
            begin
                // balanced from the very start of the list
                if (run_pos > run_best)
                    run_best = run_pos;
            end
            else
            begin
                slot = run_sum + RUN_CAP;
                if (seen[slot])
                begin
                    // same prefix seen before: the span between is balanced
                    if (run_pos - first_pos[slot] > run_best)
                        run_best = run_pos - first_pos[slot];
                end
                else
                begin
                    seen[slot]      = 1'b1;
                    first_pos[slot] = run_pos;
                end
            end
        end
        else
        begin
            // past the cap: element is dropped but the list is marked
            run_dropped = 1'b1;
        end

        if (it.final_item)
        begin
            res.longest  = LONGEST_W'(run_best);
            res.too_long = run_dropped;
            pending_runs.push_back(res);
            // fresh state for the next list
            run_sum     = 0;
            run_pos     = 0;
            run_best    = 0;
            run_dropped = 1'b0;
            foreach (seen[i])
                seen[i] = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender: optional idle gap, then hold the transaction until it is taken;
    // valid is only lowered inside a gap so it never toggles within a step
    // ------------------------------------------------------------------------
    task automatic send_item(input logic signed [SAMPLE_W-1:0] value, input logic last);
        item_t it;
        it.sample     = value;
        it.final_item = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        // stall read here is the value the block held at this edge
        while (item_stall)
            @(posedge clk);
        track_balance(it);
    endtask

    // random element; ones_pct sets how often the step is upward
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int unsigned ones_pct);
        if ($urandom_range(99) < ones_pct)
            return 32'sd1;
        case ($urandom_range(5))
            0: return 32'sd0;
            1: return -32'sd1;
            2: return 32'sh8000_0001;    // low bits look like one, sign bit set
            3: return 32'sd2;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stall at the rate of the current phase
    // ------------------------------------------------------------------------
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    task automatic note_miss(input string what, input result_t want, input result_t got);
        miss_count++;
        if (miss_count <= SHOWN_MISSES)
            $display("error at %0t: %s: expected longest=%0d too_long=%0b, %s%0d %s%0b",
                     $realtime, what, want.longest, want.too_long,
                     "got longest=", got.longest, "too_long=", got.too_long);
    endtask

    // result checker: every delivered transaction against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_runs.size() == 0)
            begin
                want = '0;
                note_miss("result with nothing expected", want, result);
            end
            else
            begin
                want = pending_runs.pop_front();
                if (result.longest !== want.longest || result.too_long !== want.too_long)
                    note_miss("wrong result", want, result);
            end
        end
    end

    // watchdog: ends the run if traffic stops on both channels
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("longest_balanced_run: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // one-element lists at the field extremes, and small lists that hit
    // the zero prefix and the table lookup
    task automatic test_short_lists();
        send_item(32'sd1, 1'b1);                  // single element, one
        send_item(32'sd0, 1'b1);                  // single element, zero
        send_item(32'sh8000_0000, 1'b1);          // most negative value
        send_item(32'sh7fff_ffff, 1'b1);          // most positive value
        send_item(32'sh8000_0001, 1'b1);          // only the low bit set plus sign
        send_item(32'sd1, 1'b0);                  // balanced from the start: 2
        send_item(-32'sd1, 1'b1);
        send_item(32'sd1, 1'b0);                  // run found through the table: 2
        send_item(32'sd1, 1'b0);
        send_item(32'sd0, 1'b1);
        send_item(32'sd0, 1'b0);                  // dips negative then climbs to zero: 4
        send_item(32'sd0, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sd1, 1'b1);
        send_item(32'sd2, 1'b0);                  // never balanced: 0
        send_item(32'sd3, 1'b0);
        send_item(32'sh7fff_ffff, 1'b1);
    endtask

    // random lists, mostly short with an occasional long one; each list picks
    // its own balance of up and down steps, the last one is cut to the budget
    task automatic test_random_lists(input int unsigned n_items,
                                     input int unsigned idle, input int unsigned stall);
        int unsigned sent;
        int unsigned len;
        int unsigned ones_pct;
        send_idle_pct = idle;
        stall_pct     = stall;
        sent          = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(25, 300)
                                           : $urandom_range(1, 24);
            if (len > n_items - sent)
                len = n_items - sent;
            ones_pct = $urandom_range(25, 75);
            for (int i = 0; i < len; i++)
                send_item(pick_sample(ones_pct), i == len - 1);
            sent += len;
        end
    endtask

    // lower valid and let every outstanding result arrive
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        // block latency is two stages plus its output queue
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        foreach (seen[i])
            seen[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_lists();

        // idling phases: none, sender gaps, receiver stalls, both
        test_random_lists(158, 0, 0);
        test_random_lists(158, 84, 0);
        test_random_lists(158, 0, 84);
        test_random_lists(158, 21, 21);

        drain();

        if (miss_count == 0)
            $display("longest_balanced_run: match");
        else
            $display("longest_balanced_run: mismatch");
        $finish;
    end

endmodule

>>> longest_balanced_run.f
sv/lbr_pkg.sv
sv/lbr_ram.sv
sv/longest_balanced_run.sv
dv/tb_longest_balanced_run.sv
